@@ design/lz77_token_decompressor_top_assert.svh @@
// assertion macros for the lz77 token decompressor
`ifndef LZ77_TOKEN_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZ77_TOKEN_DECOMPRESSOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define LZD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lz77 decompressor check failed");

// next-cycle implication, checked out of reset
`define LZD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lz77 decompressor check failed");

`else

`define LZD_ASSERT_SAME(label, ante, cons)
`define LZD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/lz77_dec_pkg.sv @@
// shared types, constants and helpers of the lz77 token decompressor
`timescale 1ns / 1ps

package lz77_dec_pkg;

    localparam int WORD_W   = 16;  // token word
    localparam int OFF_W    = 11;  // widest offset (length field is at least 5 bits)
    localparam int LENM1_W  = 8;   // widest length minus one
    localparam int REM_W    = 9;   // bytes of one token, up to 257
    localparam int CNT_W    = 12;  // common width for offset and position math
    localparam int LB_W     = 4;   // length_bits register
    localparam int LANES    = 8;   // output byte fields
    localparam int BCNT_W   = 4;   // byte_count field

    localparam logic [LB_W-1:0] LB_MIN   = 4'd5;
    localparam logic [LB_W-1:0] LB_MAX   = 4'd8;
    localparam logic [LB_W-1:0] LB_RESET = 4'd5;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_MEM  = 2'd0;  // byte read from the window
    localparam t_kind KIND_ZERO = 2'd1;  // bad offset, zero filler
    localparam t_kind KIND_LIT  = 2'd2;  // trailing literal

    typedef logic [7:0] t_byte;

    function automatic logic [LB_W-1:0] clamp_len_bits(input logic [LB_W-1:0] lb);
        logic [LB_W-1:0] r;
        r = lb;
        if (lb < LB_MIN) r = LB_MIN;
        if (lb > LB_MAX) r = LB_MAX;
        return r;
    endfunction

endpackage

@@ design/lz77_token_decompressor_top.sv @@
// lz77 token decompressor: history window memory, copy engine and output packer
// path: a token's bytes pass the window read stage, the packing buffer and the output register
// throughput: a token is taken only once the last result of the one before has been flushed;
//   the window read port paces one byte a cycle while the packer has room and the output is free;
//   each result is drained into the packer and flushed to the output before more bytes start
// reset: synchronous active-low i_rst_n clears control, position, produced count and
//   sets length_bits to 5; the window memory is not cleared
`timescale 1ns / 1ps

`include "lz77_token_decompressor_top_assert.svh"

module lz77_token_decompressor_top #(
    parameter int WINDOW_SIZE      = 2048,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // length_bits configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,

    // token input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // token_word [15:0], literal_byte [23:16]
    input  logic        s_axis_tuser,   // stream_start

    // decoded bytes output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_byte0..out_byte7 [63:0], byte_count [67:64], zero pad
    output logic        m_axis_tuser,   // offset_error
    output logic        m_axis_tlast    // last_of_token
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int PW = $clog2(WINDOW_SIZE + 1);
    // bytes packed into one result, at most the eight output lanes
    localparam int CHUNK = (BYTES_PER_RESULT < 1) ? 1 :
                           (BYTES_PER_RESULT > lz77_dec_pkg::LANES) ? lz77_dec_pkg::LANES :
                           BYTES_PER_RESULT;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // history window, one write and one registered read port
    lz77_dec_pkg::t_byte mem [WINDOW_SIZE];

    logic                          r_state;
    logic [lz77_dec_pkg::LB_W-1:0] r_length_bits;
    logic [AW-1:0]                 r_wp;
    logic [PW-1:0]                 r_produced;

    // per-token registers
    logic [lz77_dec_pkg::REM_W-1:0] r_rem;
    logic [AW-1:0]                  r_src;
    lz77_dec_pkg::t_kind            r_kind;
    lz77_dec_pkg::t_byte            r_lit;
    logic                           r_err;

    // read stage
    lz77_dec_pkg::t_byte r_rd_data;
    logic                r_fwd;
    lz77_dec_pkg::t_byte r_fwd_data;
    logic                r_v2;
    lz77_dec_pkg::t_kind r_k2;
    logic                r_last2;

    // packing buffer
    lz77_dec_pkg::t_byte                r_asm [lz77_dec_pkg::LANES];
    logic [lz77_dec_pkg::BCNT_W-1:0]    r_asm_cnt;
    logic                               r_asm_full;
    logic                               r_asm_last;

    // output register
    logic                               r_out_valid;
    lz77_dec_pkg::t_byte                r_out_bytes [lz77_dec_pkg::LANES];
    logic [lz77_dec_pkg::BCNT_W-1:0]    r_out_cnt;
    logic                               r_out_err;
    logic                               r_out_last;

    // decode of the incoming token
    logic [lz77_dec_pkg::LB_W-1:0]    lb_eff;
    logic [lz77_dec_pkg::WORD_W-1:0]  in_word;
    logic [lz77_dec_pkg::OFF_W-1:0]   in_offset;
    logic [lz77_dec_pkg::LENM1_W-1:0] in_len_m1;
    logic [PW-1:0]                    prod_eff;
    logic                             in_err;
    logic                             in_copy;
    logic [lz77_dec_pkg::CNT_W-1:0]   wp_ext;
    logic [lz77_dec_pkg::CNT_W-1:0]   off_ext;
    logic [lz77_dec_pkg::CNT_W-1:0]   src_ext;
    logic                             accept;

    logic                accept_cfg;
    logic                issue;
    lz77_dec_pkg::t_kind issue_kind;
    lz77_dec_pkg::t_byte s2_byte;
    logic                flush;
    logic [AW-1:0]       n_wp;
    logic [AW-1:0]       n_src;
    logic                n_state;

    assign accept_cfg    = i_cfg_valid;
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        lb_eff    = lz77_dec_pkg::clamp_len_bits(r_length_bits);
        in_word   = s_axis_tdata[15:0];
        in_offset = lz77_dec_pkg::OFF_W'(in_word >> lb_eff);
        in_len_m1 = lz77_dec_pkg::LENM1_W'(in_word & ((16'd1 << lb_eff) - 16'd1));
        prod_eff  = s_axis_tuser ? '0 : r_produced;
        in_copy   = (in_offset != '0);
        in_err    = in_copy && ({1'b0, in_offset} > lz77_dec_pkg::CNT_W'(prod_eff));
        wp_ext    = lz77_dec_pkg::CNT_W'(r_wp);
        off_ext   = lz77_dec_pkg::CNT_W'(in_offset);
        // source of the first copied byte, wraps below zero into the window
        if (wp_ext >= off_ext) begin
            src_ext = wp_ext - off_ext;
        end else begin
            src_ext = wp_ext + lz77_dec_pkg::CNT_W'(WINDOW_SIZE) - off_ext;
        end
    end

    // one byte is started per cycle while the packer has room for it and the one in flight
    always_comb begin
        issue = (r_state == ST_RUN) && (r_rem != '0) && !r_asm_full &&
                ((5'(r_asm_cnt) + 5'(r_v2)) < 5'(CHUNK));
        issue_kind = (r_rem == lz77_dec_pkg::REM_W'(1)) ? lz77_dec_pkg::KIND_LIT : r_kind;
        n_wp  = (r_wp == AW'(WINDOW_SIZE - 1)) ? '0 : r_wp + AW'(1);
        n_src = (r_src == AW'(WINDOW_SIZE - 1)) ? '0 : r_src + AW'(1);
    end

    // byte of the read stage; with offset one the read overlaps last cycle's write
    always_comb begin
        case (r_k2)
            lz77_dec_pkg::KIND_LIT:  s2_byte = r_lit;
            lz77_dec_pkg::KIND_ZERO: s2_byte = '0;
            lz77_dec_pkg::KIND_MEM:  s2_byte = r_fwd ? r_fwd_data : r_rd_data;
            default:                 s2_byte = '0;
        endcase
    end

    assign flush = r_asm_full && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (flush && r_asm_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            mem[r_wp] <= s2_byte;
        end
        r_rd_data <= mem[r_src];
    end

    // control and position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_length_bits <= lz77_dec_pkg::LB_RESET;
            r_wp          <= '0;
            r_produced    <= '0;
            r_rem         <= '0;
            r_v2          <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept_cfg) r_length_bits <= i_cfg_data;
            if (accept) begin
                r_rem <= in_copy ? lz77_dec_pkg::REM_W'(in_len_m1) + lz77_dec_pkg::REM_W'(2)
                                 : lz77_dec_pkg::REM_W'(1);
                if (s_axis_tuser) r_produced <= '0;
            end else if (issue) begin
                r_rem <= r_rem - lz77_dec_pkg::REM_W'(1);
            end
            r_v2 <= issue;
            if (r_v2) begin
                r_wp <= n_wp;
                if (r_produced != PW'(WINDOW_SIZE)) r_produced <= r_produced + PW'(1);
            end
        end
    end

    // token payload and read stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src  <= AW'(src_ext);
            r_kind <= in_err ? lz77_dec_pkg::KIND_ZERO : lz77_dec_pkg::KIND_MEM;
            r_lit  <= s_axis_tdata[23:16];
            r_err  <= in_err;
        end else if (issue) begin
            r_src <= n_src;
        end
        r_fwd      <= r_v2 && (r_wp == r_src);
        r_fwd_data <= s2_byte;
        r_k2       <= issue_kind;
        r_last2    <= (r_rem == lz77_dec_pkg::REM_W'(1));
    end

    // packing buffer, lanes past the count stay zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lz77_dec_pkg::LANES; i++) r_asm[i] <= '0;
            r_asm_cnt  <= '0;
            r_asm_full <= 1'b0;
            r_asm_last <= 1'b0;
        end else if (flush) begin
            for (int i = 0; i < lz77_dec_pkg::LANES; i++) r_asm[i] <= '0;
            r_asm_cnt  <= '0;
            r_asm_full <= 1'b0;
            r_asm_last <= 1'b0;
        end else if (r_v2) begin
            r_asm[r_asm_cnt[2:0]] <= s2_byte;
            r_asm_cnt  <= r_asm_cnt + lz77_dec_pkg::BCNT_W'(1);
            r_asm_full <= (r_asm_cnt + lz77_dec_pkg::BCNT_W'(1) ==
                           lz77_dec_pkg::BCNT_W'(CHUNK)) || r_last2;
            r_asm_last <= r_last2;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (flush) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (flush) begin
            for (int i = 0; i < lz77_dec_pkg::LANES; i++) r_out_bytes[i] <= r_asm[i];
            r_out_cnt  <= r_asm_cnt;
            r_out_err  <= r_err;
            r_out_last <= r_asm_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_cnt,
                            r_out_bytes[7], r_out_bytes[6], r_out_bytes[5], r_out_bytes[4],
                            r_out_bytes[3], r_out_bytes[2], r_out_bytes[1], r_out_bytes[0]};
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

    // a token is taken only with the packer and the read stage drained
    `LZD_ASSERT_SAME(a_idle_drained, s_axis_tready, (r_asm_cnt == '0) && !r_v2 && !r_asm_full)
    // a byte never lands in a full packing buffer
    `LZD_ASSERT_SAME(a_no_overfill, r_v2, (r_asm_cnt < lz77_dec_pkg::BCNT_W'(CHUNK)) && !r_asm_full)
    // every result carries at least one byte
    `LZD_ASSERT_SAME(a_out_nonempty, m_axis_tvalid, (r_out_cnt != '0))
    // the last result of a token frees the input side next cycle
    `LZD_ASSERT_NEXT(a_last_frees, flush && r_asm_last, s_axis_tready)

endmodule
